// ===== rtl/core/ccp_pkg.sv =====
// Shared types, constants and helper functions of the Cache-Control header parser.
package ccp_pkg;

	localparam int NUM_PAT     = 11;
	localparam int NUM_KW      = 7;
	localparam int NUM_VAL     = 4;
	localparam int SEL_W       = $clog2(NUM_VAL);
	localparam int PAT_MAX_LEN = 23;
	localparam int POS_W       = 5;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Keywords first, then the four value prefixes in output order.
	localparam logic [PAT_MAX_LEN*8-1:0] PAT_TEXT [NUM_PAT] = '{
		"no-cache", "no-store", "must-revalidate", "proxy-revalidate",
		"public", "private", "immutable",
		"max-age=", "s-maxage=", "stale-while-revalidate=", "stale-if-error="
	};
	localparam logic [POS_W-1:0] PAT_LEN [NUM_PAT] = '{
		5'd8, 5'd8, 5'd15, 5'd16, 5'd6, 5'd7, 5'd9, 5'd8, 5'd9, 5'd23, 5'd15
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		VP_NAME,
		VP_SKIP,
		VP_DIGITS,
		VP_DONE
	} val_phase_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
		logic       space;
		logic       comma;
		logic       digit;
		logic [3:0] dval;
	} ccp_item_t;

	typedef struct packed {
		logic [NUM_PAT-1:0] alive;
		logic [POS_W-1:0]   pos;
		logic               seen;
		logic               pend;
		val_phase_t         phase;
		logic [SEL_W-1:0]   sel;
	} dir_state_t;

	localparam dir_state_t DIR_CLEAR = '{
		alive: '1,
		pos:   '0,
		seen:  1'b0,
		pend:  1'b0,
		phase: VP_NAME,
		sel:   '0
	};

	function automatic ccp_item_t classify(input logic [7:0] chr, input logic last);
		ccp_item_t it;
		it.chr   = chr;
		it.last  = last;
		it.space = (chr == CH_SPACE);
		it.comma = (chr == CH_COMMA);
		it.digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
		it.dval  = chr[3:0];
		return it;
	endfunction

	// True when pattern idx holds character chr at position pos.
	function automatic logic pat_hit(input int unsigned idx, input logic [POS_W-1:0] pos,
			input logic [7:0] chr);
		logic [POS_W-1:0] bidx;
		logic [7:0]       tc;
		bidx = PAT_LEN[idx] - pos - POS_W'(1);
		tc   = PAT_TEXT[idx][{bidx, 3'b000} +: 8];
		return (pos < PAT_LEN[idx]) && (tc == chr);
	endfunction

endpackage

// ===== rtl/core/ccp_in_if.sv =====
// Byte stream channel carrying header characters into the parser.
interface ccp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       is_last;

	modport source(output valid, header_byte, is_last, input ready);
	modport sink(input valid, header_byte, is_last, output ready);
endinterface

// ===== rtl/core/ccp_out_if.sv =====
// Result channel carrying the decoded Cache-Control directives.
interface ccp_out_if;
	logic        valid;
	logic        ready;
	logic        cc_nocache;
	logic        cc_nostore;
	logic        cc_mustreval;
	logic        cc_proxyreval;
	logic        cc_public;
	logic        cc_private;
	logic        immutable;
	logic [31:0] max_age;
	logic [31:0] shared_max_age;
	logic [31:0] stale_revalidate_window;
	logic [31:0] stale_error_window;
	logic        parse_error;

	modport source(output valid, cc_nocache, cc_nostore, cc_mustreval, cc_proxyreval,
		cc_public, cc_private, immutable, max_age, shared_max_age,
		stale_revalidate_window, stale_error_window, parse_error, input ready);
	modport sink(input valid, cc_nocache, cc_nostore, cc_mustreval, cc_proxyreval,
		cc_public, cc_private, immutable, max_age, shared_max_age,
		stale_revalidate_window, stale_error_window, parse_error, output ready);
endinterface

// ===== rtl/core/ccp_front.sv =====
// Front stage: accepts header bytes and registers them with their character class.
module ccp_front (
	input  logic              clk,
	input  logic              arst_n,
	ccp_in_if.sink            hdr,
	output logic              push_valid,
	input  logic              push_ready,
	output ccp_pkg::ccp_item_t push_item
);
	import ccp_pkg::*;

	logic      valid_s1;
	ccp_item_t item_s1;
	logic      take;

	assign hdr.ready  = !valid_s1 || push_ready;
	assign take       = hdr.valid && hdr.ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= classify(hdr.header_byte, hdr.is_last);
		end
	end

endmodule

// ===== rtl/core/ccp_queue.sv =====
// Small FIFO that decouples the classifying front from the parsing back end.
module ccp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ccp_pkg::ccp_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ccp_pkg::ccp_item_t pop_item
);
	import ccp_pkg::*;

	ccp_item_t             slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/ccp_back.sv =====
// Back end: directive matching, value accumulation and the registered result.
module ccp_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ccp_pkg::ccp_item_t item,
	ccp_out_if.source          res
);
	import ccp_pkg::*;

	localparam int MW = VALUE_BITS + 4;

	dir_state_t              dir_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic                    dseen_q;
	logic [NUM_KW-1:0]       flags_q;
	logic [VALUE_BITS-1:0]   vals_q [NUM_VAL];
	logic                    err_q;

	logic                    res_valid_q;
	logic [NUM_KW-1:0]       rflags_q;
	logic [VALUE_BITS-1:0]   rvals_q [NUM_VAL];
	logic                    rerr_q;

	dir_state_t              a_dir;
	logic [VALUE_BITS-1:0]   a_acc;
	logic                    a_dseen;
	logic                    a_err;
	logic [NUM_PAT-1:0]      mask;
	logic                    hit;
	logic [MW-1:0]           mul;
	logic                    ovf;
	logic [VALUE_BITS-1:0]   acc_sat;
	logic                    do_end;
	logic [NUM_KW-1:0]       e_flags;
	logic [VALUE_BITS-1:0]   e_vals [NUM_VAL];
	logic                    e_err;
	logic                    pop;

	assign item_ready = !item.last || !res_valid_q || res.ready;
	assign pop        = item_valid && item_ready;

	// acc * 10 + digit, saturating at the top of the value range.
	assign mul     = MW'({acc_q, 3'b000}) + MW'({acc_q, 1'b0}) + MW'(item.dval);
	assign ovf     = |mul[MW-1:VALUE_BITS];
	assign acc_sat = ovf ? '1 : mul[VALUE_BITS-1:0];

	// Effect of one non-comma byte on the current directive.
	always_comb begin
		a_dir   = dir_q;
		a_acc   = acc_q;
		a_dseen = dseen_q;
		a_err   = err_q;
		mask    = dir_q.pend ? '0 : dir_q.alive;
		hit     = 1'b0;
		if (!item.comma) begin
			unique case (dir_q.phase) inside
				VP_NAME: begin
					if (item.space) begin
						if (dir_q.seen) begin
							a_dir.pend = 1'b1;
						end
					end else begin
						for (int i = 0; i < NUM_PAT; i++) begin
							a_dir.alive[i] = mask[i] && pat_hit(i, dir_q.pos, item.chr);
						end
						a_dir.seen = 1'b1;
						a_dir.pos  = (dir_q.pos != POS_MAX) ? dir_q.pos + POS_W'(1)
							: dir_q.pos;
						for (int i = NUM_KW; i < NUM_PAT; i++) begin
							if (!hit && a_dir.alive[i] && (a_dir.pos == PAT_LEN[i])) begin
								hit         = 1'b1;
								a_dir.phase = VP_SKIP;
								a_dir.sel   = SEL_W'(i - NUM_KW);
								a_acc       = '0;
								a_dseen     = 1'b0;
							end
						end
					end
				end
				VP_SKIP, VP_DIGITS: begin
					if (item.digit) begin
						a_acc       = acc_sat;
						a_dseen     = 1'b1;
						a_dir.phase = VP_DIGITS;
						a_err       = err_q || ovf;
					end else if (!(item.space && (dir_q.phase == VP_SKIP))) begin
						a_dir.phase = VP_DONE;
					end
				end
				VP_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Directive close on a comma or on the last byte. On a comma a_* still holds
	// the current state, so one close path serves both.
	always_comb begin
		do_end  = item.comma || item.last;
		e_flags = flags_q;
		e_vals  = vals_q;
		e_err   = a_err;
		if (do_end) begin
			if (a_dir.phase != VP_NAME) begin
				if (a_dseen) begin
					e_vals[a_dir.sel] = a_acc;
				end else begin
					e_err = 1'b1;
				end
			end else if (a_dir.seen) begin
				for (int i = 0; i < NUM_KW; i++) begin
					if (a_dir.alive[i] && (a_dir.pos == PAT_LEN[i])) begin
						e_flags[i] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_CLEAR;
			acc_q   <= '0;
			dseen_q <= 1'b0;
			flags_q <= '0;
			err_q   <= 1'b0;
			for (int i = 0; i < NUM_VAL; i++) begin
				vals_q[i] <= '0;
			end
		end else if (pop) begin
			if (do_end) begin
				dir_q   <= DIR_CLEAR;
				acc_q   <= '0;
				dseen_q <= 1'b0;
			end else begin
				dir_q   <= a_dir;
				acc_q   <= a_acc;
				dseen_q <= a_dseen;
			end
			if (item.last) begin
				flags_q <= '0;
				err_q   <= 1'b0;
				for (int i = 0; i < NUM_VAL; i++) begin
					vals_q[i] <= '0;
				end
			end else begin
				flags_q <= e_flags;
				err_q   <= e_err;
				vals_q  <= e_vals;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			rflags_q <= e_flags;
			rvals_q  <= e_vals;
			rerr_q   <= e_err;
		end
	end

	assign res.valid                   = res_valid_q;
	assign res.cc_nocache              = rflags_q[0];
	assign res.cc_nostore              = rflags_q[1];
	assign res.cc_mustreval            = rflags_q[2];
	assign res.cc_proxyreval           = rflags_q[3];
	assign res.cc_public               = rflags_q[4];
	assign res.cc_private              = rflags_q[5];
	assign res.immutable               = rflags_q[6];
	assign res.max_age                 = 32'(rvals_q[0]);
	assign res.shared_max_age          = 32'(rvals_q[1]);
	assign res.stale_revalidate_window = 32'(rvals_q[2]);
	assign res.stale_error_window      = 32'(rvals_q[3]);
	assign res.parse_error             = rerr_q;

endmodule

// ===== rtl/core/cache_control_header_parser.sv =====
// Cache-Control header parser: one header byte per cycle, one result per header.
// Path: front register, queue slot, then the result register in the back end.
// Throughput: one byte per cycle, set by the directive matcher in
// the back end; a last byte waits only while the previous result is untaken.
// Reset: arst_n clears all handshake, queue and directive state at once; the
// result data registers keep their contents until the first result loads them.
module cache_control_header_parser #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ccp_in_if.sink     hdr,
	ccp_out_if.source  res
);
	import ccp_pkg::*;

	// Front to queue.
	logic      f_valid;
	logic      f_ready;
	ccp_item_t f_item;

	// Queue to back end.
	logic      q_valid;
	logic      q_ready;
	ccp_item_t q_item;

	// The front registers each incoming byte together with its character class
	// (space, comma, decimal digit), so the back end sees pre-decoded bytes.
	ccp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr        (hdr),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item)
	);

	// A short FIFO sits between the two halves. It absorbs the cycles during
	// which the back end holds a last byte because its result register is
	// still occupied, so the input side keeps taking transactions.
	ccp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// The back end tracks the current directive: which of the eleven patterns
	// are still alive, the matched position, trailing-space handling and, once
	// a value prefix matched, the decimal accumulator. Commas and the last byte
	// close a directive. The last byte also loads the result register and
	// returns all per-header state to its reset value.
	ccp_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.res        (res)
	);

`ifndef NO_ASSERTIONS
	// A last byte never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_item.last && res.valid) |-> res.ready)
		else $error("result overwritten before it was taken");

	// Each last byte consumed by the back end yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_item.last) |=> res.valid)
		else $error("last byte consumed without a result");

	// The input stalls only when the front stage is full and the queue is full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!hdr.ready |-> (f_valid && !f_ready))
		else $error("input stalled without back pressure");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench of the Cache-Control header parser: random header streams checked against a predictor.
module tb;
	import ccp_pkg::*;

	// The slowest correct run is roughly 1800 bytes, each behind a random input gap, plus
	// about a hundred results that each wait out a long receiver stall. This
	// limit leaves a wide margin over that.
	localparam int CYCLE_LIMIT = 300000;
	localparam int BEAT_TARGET = 1750;
	localparam int DRAIN_CYCLES = 12;

	// One input transaction: a header byte and its end-of-header mark.
	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} header_beat_t;

	// The decoded summary of one header, in the order of the result channel.
	// Bit i of flags belongs to keyword i, and secs[0] is max-age.
	typedef struct packed {
		logic [NUM_KW-1:0]         flags;
		logic [NUM_VAL-1:0][31:0] secs;
		logic                      err;
	} directive_summary_t;

	logic clk;
	logic arst_n;

	ccp_in_if  hdr ();
	ccp_out_if res ();

	cache_control_header_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Directive texts: the seven keywords first, then the four value prefixes in
	// the order of the value outputs.
	string directive_text [NUM_PAT] = '{
		"no-cache", "no-store", "must-revalidate", "proxy-revalidate",
		"public", "private", "immutable",
		"max-age=", "s-maxage=", "stale-while-revalidate=", "stale-if-error="
	};
	string flag_names [NUM_KW] = '{
		"cc_nocache", "cc_nostore", "cc_mustreval", "cc_proxyreval",
		"cc_public", "cc_private", "immutable"
	};
	string window_names [NUM_VAL] = '{
		"max_age", "shared_max_age", "stale_revalidate_window", "stale_error_window"
	};
	// Values around the 32-bit ceiling, with and without leading zeros.
	string boundary_values [6] = '{
		"4294967295", "4294967296", "4294967294", "99999999999",
		"0000000000000000004294967295", "0"
	};

	header_beat_t       beats_pending [$];
	directive_summary_t results_due [$];
	logic [7:0]         draft [$];

	int unsigned failures;
	int unsigned headers_seen;
	int unsigned cycles;

	// Predictor state for the directive being parsed.
	logic [NUM_PAT-1:0] cand_mask;
	logic [POS_W-1:0]   name_len;
	logic               name_started;
	logic               space_pending;
	val_phase_t         val_phase;
	logic [SEL_W-1:0]   val_slot;
	logic [63:0]        val_accum;
	logic               val_has_digit;
	// Predictor state for the whole header.
	logic [NUM_KW-1:0]         kw_flags;
	logic [NUM_VAL-1:0][31:0] val_regs;
	logic                      err_seen;

	// A comma or the end of the header closes a directive. A value directive
	// stores its number or, when no digit came, raises the error flag. A name
	// directive sets its keyword flag only when the full keyword survived.
	task automatic close_directive();
		if (val_phase != VP_NAME) begin
			if (val_has_digit)
				val_regs[val_slot] = val_accum[31:0];
			else
				err_seen = 1'b1;
		end else if (name_started) begin
			for (int i = 0; i < NUM_KW; i++)
				if (cand_mask[i] && name_len == directive_text[i].len())
					kw_flags[i] = 1'b1;
		end
		cand_mask     = '1;
		name_len      = '0;
		name_started  = 1'b0;
		space_pending = 1'b0;
		val_phase     = VP_NAME;
		val_slot      = '0;
		val_accum     = '0;
		val_has_digit = 1'b0;
	endtask

	// Advances the predictor by one accepted byte and queues the summary that
	// the header's last byte produces.
	task automatic absorb_byte(input logic [7:0] c, input logic last);
		logic [63:0] grown;
		int unsigned p;
		if (c == CH_COMMA) begin
			close_directive();
		end else if (val_phase != VP_NAME) begin
			// Once the digits have ended, the rest of the directive is ignored.
			if (val_phase != VP_DONE) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					grown = val_accum * 64'd10 + (64'(c) - 64'(CH_ZERO));
					if (grown > 64'hFFFF_FFFF) begin
						grown    = 64'hFFFF_FFFF;
						err_seen = 1'b1;
					end
					val_accum     = grown;
					val_has_digit = 1'b1;
					val_phase     = VP_DIGITS;
				end else if (!(c == CH_SPACE && val_phase == VP_SKIP)) begin
					val_phase = VP_DONE;
				end
			end
		end else if (c == CH_SPACE) begin
			if (name_started)
				space_pending = 1'b1;
		end else begin
			// A character after an inner space spoils every candidate.
			if (space_pending)
				cand_mask = '0;
			name_started = 1'b1;
			p = 32'(name_len);
			for (int i = 0; i < NUM_PAT; i++)
				if (cand_mask[i] && (p >= directive_text[i].len() ||
						8'(directive_text[i][p]) != c))
					cand_mask[i] = 1'b0;
			if (name_len != POS_MAX)
				name_len = name_len + POS_W'(1);
			// A completed value prefix switches over to number parsing.
			for (int i = NUM_KW; i < NUM_PAT; i++)
				if (cand_mask[i] && name_len == directive_text[i].len()) begin
					val_phase     = VP_SKIP;
					val_slot      = SEL_W'(i - NUM_KW);
					val_accum     = '0;
					val_has_digit = 1'b0;
				end
		end
		if (last) begin
			close_directive();
			results_due.push_back('{flags: kw_flags, secs: val_regs, err: err_seen});
			kw_flags = '0;
			val_regs = '0;
			err_seen = 1'b0;
		end
	endtask

	task automatic note_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 10)
				$display("mismatch in %s of header %0d: expected %0d, got %0d",
					field, headers_seen, want, got);
		end
	endtask

	// Helpers that build one header in the draft and then queue its bytes.
	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(8'(s[i]));
	endtask

	task automatic append_spaces(input int unsigned n);
		repeat (n) draft.push_back(CH_SPACE);
	endtask

	task automatic append_digits(input int unsigned n);
		repeat (n) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic commit_header();
		// An empty header cannot be sent, so a lone random byte stands in.
		if (draft.size() == 0)
			draft.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < draft.size(); i++)
			beats_pending.push_back('{chr: draft[i], last: (i == draft.size() - 1)});
		draft.delete();
	endtask

	// A number after a value prefix: short values, values at the 32-bit ceiling, long digit runs,
	// no digits at all, or a sign, followed by one of several kinds of tail.
	task automatic append_value();
		append_spaces(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		case ($urandom_range(0, 5))
			0, 1: append_digits($urandom_range(1, 6));
			2: append_text(boundary_values[$urandom_range(0, 5)]);
			3: append_digits($urandom_range(9, 14));
			4: ;
			default: begin
				append_text(($urandom_range(0, 1) == 0) ? "+" : "-");
				append_digits($urandom_range(0, 3));
			end
		endcase
		case ($urandom_range(0, 6))
			0: begin
				append_spaces(1);
				append_digits($urandom_range(1, 3));
			end
			1: append_text("x");
			2: draft.push_back(8'h09);
			3: append_text(";q=1");
			default: ;
		endcase
	endtask

	// A damaged directive: one character replaced, cut short, split by an inner
	// space, extended, or with its first letter in upper case.
	task automatic append_damaged();
		string s;
		int unsigned op;
		int unsigned k;
		s  = directive_text[$urandom_range(0, NUM_PAT - 1)];
		op = $urandom_range(0, 4);
		k  = $urandom_range(1, s.len() - 1);
		for (int i = 0; i < s.len(); i++) begin
			if (op == 1 && i == k)
				break;
			if (op == 2 && i == k)
				draft.push_back(CH_SPACE);
			if (op == 0 && i == k)
				draft.push_back(8'($urandom_range(0, 255)));
			else if (op == 4 && i == 0)
				draft.push_back(8'(s[i]) - 8'h20);
			else
				draft.push_back(8'(s[i]));
		end
		if (op == 3) begin
			append_spaces($urandom_range(0, 1));
			draft.push_back(8'h61 + 8'($urandom_range(0, 25)));
		end
		if ($urandom_range(0, 1) == 0)
			append_digits($urandom_range(1, 4));
	endtask

	task automatic append_directive();
		int unsigned kind;
		kind = $urandom_range(0, 99);
		append_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
		if (kind < 30) begin
			append_text(directive_text[$urandom_range(0, NUM_KW - 1)]);
		end else if (kind < 62) begin
			append_text(directive_text[$urandom_range(NUM_KW, NUM_PAT - 1)]);
			append_value();
		end else if (kind < 78) begin
			append_damaged();
		end else if (kind < 86) begin
			repeat ($urandom_range(1, 8)) draft.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			// Long names run the position counter into saturation.
			repeat ($urandom_range(30, 40)) draft.push_back(8'h61 + 8'($urandom_range(0, 25)));
		end
		append_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
	endtask

	// Driver. A byte stays on the channel until it is taken; new bytes go out in
	// bursts of random length with random gaps between them.
	logic byte_taken;
	int   burst_left;
	int   gap_left;

	always @(negedge clk) begin
		if (!arst_n) begin
			hdr.valid <= 1'b0;
		end else if (!(hdr.valid && !byte_taken)) begin
			if (byte_taken && burst_left > 0)
				burst_left--;
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 16);
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0) begin
				gap_left--;
				hdr.valid <= 1'b0;
			end else if (beats_pending.size() != 0) begin
				hdr.valid       <= 1'b1;
				hdr.header_byte <= beats_pending[0].chr;
				hdr.is_last     <= beats_pending[0].last;
			end else begin
				hdr.valid <= 1'b0;
			end
		end
	end

	// Receiver. It picks a new mode at regular points of its tick counter: always ready, ready half the
	// time, ready a quarter of the time, or a fixed one-in-eight pattern.
	int unsigned sink_tick;
	int unsigned sink_mode;

	always @(negedge clk) begin
		if (sink_tick % 48 == 0)
			sink_mode = $urandom_range(0, 3);
		sink_tick++;
		case (sink_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= ($urandom_range(0, 1) == 0);
			2: res.ready <= ($urandom_range(0, 3) == 0);
			default: res.ready <= (sink_tick % 8 == 0);
		endcase
	end

	// Monitor and predictor share one block, so a result is always checked
	// before any header byte taken at the same edge is applied.
	always @(posedge clk) begin : watch_channels
		header_beat_t       beat;
		directive_summary_t want;
		directive_summary_t got;
		byte_taken <= hdr.valid && hdr.ready;
		if (res.valid && res.ready) begin
			got.flags = {res.immutable, res.cc_private, res.cc_public, res.cc_proxyreval,
				res.cc_mustreval, res.cc_nostore, res.cc_nocache};
			got.secs  = {res.stale_error_window, res.stale_revalidate_window,
				res.shared_max_age, res.max_age};
			got.err   = res.parse_error;
			if (results_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result transaction with no header pending");
			end else begin
				want = results_due.pop_front();
				for (int i = 0; i < NUM_KW; i++)
					note_field(flag_names[i], 32'(want.flags[i]), 32'(got.flags[i]));
				for (int i = 0; i < NUM_VAL; i++)
					note_field(window_names[i], want.secs[i], got.secs[i]);
				note_field("parse_error", 32'(want.err), 32'(got.err));
			end
			headers_seen++;
		end
		if (hdr.valid && hdr.ready) begin
			beat = beats_pending.pop_front();
			absorb_byte(beat.chr, beat.last);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		hdr.valid       = 1'b0;
		hdr.header_byte = '0;
		hdr.is_last     = 1'b0;
		res.ready       = 1'b0;
		byte_taken      = 1'b0;
		burst_left      = 0;
		gap_left        = 0;
		sink_tick       = 0;
		sink_mode       = 0;
		failures        = 0;
		headers_seen    = 0;
		cycles          = 0;
		kw_flags        = '0;
		val_regs        = '0;
		err_seen        = 1'b0;
		close_directive();

		// Directed headers: a lone byte above 0x7F, a lone comma, and a header
		// with an overflowing value and a signed one.
		draft.push_back(8'hFF);
		commit_header();
		draft.push_back(CH_COMMA);
		commit_header();
		append_text("max-age=4294967296,s-maxage=-1");
		commit_header();

		// Random headers of one to four directives, at times with a trailing
		// comma, and now and then a one-byte header.
		while (beats_pending.size() < BEAT_TARGET) begin
			if ($urandom_range(0, 19) == 0) begin
				draft.push_back(8'($urandom_range(0, 255)));
			end else begin
				append_directive();
				repeat ($urandom_range(0, 3)) begin
					draft.push_back(CH_COMMA);
					append_directive();
				end
				if ($urandom_range(0, 7) == 0)
					draft.push_back(CH_COMMA);
			end
			commit_header();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_pending.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ccp_pkg.sv
rtl/core/ccp_in_if.sv
rtl/core/ccp_out_if.sv
rtl/core/ccp_front.sv
rtl/core/ccp_queue.sv
rtl/core/ccp_back.sv
rtl/core/cache_control_header_parser.sv
tb/tb.sv
